// File: hdl/ssf_pkg.sv
package ssf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int WINDOW_MAX  = 64;

	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
	localparam int LEN_W      = FILL_W;
	localparam int LEN_CFG_W  = 7;
	localparam int GAIN_W     = 16;
	localparam int COUNT_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W      = SAMPLE_BITS + PTR_W + 1;
	localparam int MAG_W      = SUM_W - 1;
	localparam int DIV_CNT_W  = $clog2(MAG_W);
	localparam int ALPHA_FRAC = 15;
	localparam int PROD_W     = SAMPLE_BITS + 1 + GAIN_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(64'd1 << ALPHA_FRAC);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (ALPHA_FRAC - 1));

	localparam logic signed [SUM_W-1:0] SMP_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SMP_LO = -SMP_HI - SUM_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LEN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(2);

	localparam logic MODE_EXP = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_EXP,
		ST_SUM,
		ST_DRAIN,
		ST_DIVINIT,
		ST_DIV,
		ST_DIVFIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic exp_fin;
		logic rd_start;
		logic rd_issue;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mode_avg;
		logic fill_ge_len;
		logic rd_last;
		logic div_last;
		logic out_free;
		logic emit_last;
	} status_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] wl);
		logic [LEN_W-1:0] r;
		if (wl == '0)
			r = LEN_W'(1);
		else if (int'(wl) > WINDOW_MAX)
			r = LEN_W'(WINDOW_MAX);
		else
			r = LEN_W'(wl);
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return (g > GAIN_ONE) ? GAIN_ONE : g;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > SMP_HI)
			r = SMP_HI;
		else if (v < SMP_LO)
			r = SMP_LO;
		else
			r = v;
		return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

// File: hdl/ssf_ram.sv
module ssf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: hdl/ssf_ctrl.sv
module ssf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ssf_pkg::status_t  status,
	output ssf_pkg::cmd_t     cmd
);

	ssf_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssf_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ssf_pkg::ST_IDLE: begin
				if (item_valid)
					state_nxt = ssf_pkg::ST_LOAD;
			end
			ssf_pkg::ST_LOAD: begin
				if (!status.mode_avg)
					state_nxt = ssf_pkg::ST_MUL;
				else if (status.fill_ge_len)
					state_nxt = ssf_pkg::ST_SUM;
				else
					state_nxt = ssf_pkg::ST_IDLE;
			end
			ssf_pkg::ST_MUL:     state_nxt = ssf_pkg::ST_EXP;
			ssf_pkg::ST_EXP:     state_nxt = ssf_pkg::ST_EMIT;
			ssf_pkg::ST_SUM: begin
				if (status.rd_last)
					state_nxt = ssf_pkg::ST_DRAIN;
			end
			ssf_pkg::ST_DRAIN:   state_nxt = ssf_pkg::ST_DIVINIT;
			ssf_pkg::ST_DIVINIT: state_nxt = ssf_pkg::ST_DIV;
			ssf_pkg::ST_DIV: begin
				if (status.div_last)
					state_nxt = ssf_pkg::ST_DIVFIN;
			end
			ssf_pkg::ST_DIVFIN:  state_nxt = ssf_pkg::ST_EMIT;
			ssf_pkg::ST_EMIT: begin
				if (status.out_free && status.emit_last)
					state_nxt = ssf_pkg::ST_IDLE;
			end
			default:             state_nxt = ssf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = (state_q != ssf_pkg::ST_IDLE);
		unique case (state_q)
			ssf_pkg::ST_IDLE:    cmd.accept   = item_valid;
			ssf_pkg::ST_LOAD:    cmd.rd_start = status.mode_avg && status.fill_ge_len;
			ssf_pkg::ST_MUL:     cmd.mul      = 1'b1;
			ssf_pkg::ST_EXP:     cmd.exp_fin  = 1'b1;
			ssf_pkg::ST_SUM:     cmd.rd_issue = 1'b1;
			ssf_pkg::ST_DRAIN:   cmd          = '0;
			ssf_pkg::ST_DIVINIT: cmd.div_init = 1'b1;
			ssf_pkg::ST_DIV:     cmd.div_step = 1'b1;
			ssf_pkg::ST_DIVFIN:  cmd.div_fin  = 1'b1;
			ssf_pkg::ST_EMIT:    cmd.emit     = status.out_free;
			default:             cmd          = '0;
		endcase
	end

endmodule

// File: hdl/ssf_dp.sv
module ssf_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [ssf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [ssf_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   record_start,
	input  logic                                   result_stall,
	output logic                                   result_valid,
	output logic signed [ssf_pkg::SAMPLE_BITS-1:0] filtered_sample,
	output logic [ssf_pkg::COUNT_W-1:0]            crossing_count,
	output logic                                   burst_last,
	input  ssf_pkg::cmd_t                          cmd,
	output ssf_pkg::status_t                       status
);

	localparam int SB = ssf_pkg::SAMPLE_BITS;
	localparam int SW = ssf_pkg::SUM_W;

	// configuration
	logic                           cfg_mode_q;
	logic [ssf_pkg::LEN_CFG_W-1:0]  cfg_len_q;
	logic [ssf_pkg::GAIN_W-1:0]     cfg_gain_q;
	logic [ssf_pkg::LEN_W-1:0]      len_eff;
	logic [ssf_pkg::GAIN_W-1:0]     alpha;

	// record state
	logic                           active_q;
	logic signed [SB-1:0]           prev_samp_q;
	logic signed [SB-1:0]           prev_out_q;
	logic [ssf_pkg::COUNT_W-1:0]    count_q;
	logic [ssf_pkg::FILL_W-1:0]     fill_q;
	logic [ssf_pkg::FILL_W-1:0]     prev_fill_q;
	logic [ssf_pkg::PTR_W-1:0]      wp_q;

	// accept-cycle view of the state after an optional record clear
	logic                           cur_active;
	logic signed [SB-1:0]           cur_prev_samp;
	logic [ssf_pkg::COUNT_W-1:0]    cur_count;
	logic [ssf_pkg::FILL_W-1:0]     cur_fill;
	logic [ssf_pkg::PTR_W-1:0]      cur_wp;
	logic                           crossed;

	// item work registers
	logic signed [SB-1:0]           x_q;
	logic                           first_q;
	logic signed [ssf_pkg::PROD_W-1:0] product_s1;
	logic signed [SB:0]             diff;
	logic signed [ssf_pkg::PROD_W-1:0] rounded;
	logic signed [ssf_pkg::PROD_W-1:0] step;
	logic signed [SW-1:0]           exp_wide;
	logic signed [SB-1:0]           exp_y;

	logic [ssf_pkg::PTR_W-1:0]      k_q;
	logic [ssf_pkg::PTR_W:0]        addr_raw;
	logic [ssf_pkg::PTR_W-1:0]      rd_addr;
	logic                           rd_vld_s1;
	logic [SB-1:0]                  rdata;
	logic signed [SW-1:0]           sum_q;

	logic                           neg_q;
	logic [ssf_pkg::MAG_W-1:0]      quo_q;
	logic [ssf_pkg::LEN_W-1:0]      rem_q;
	logic [ssf_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic [ssf_pkg::LEN_W:0]        shifted;
	logic [ssf_pkg::LEN_W:0]        trial;
	logic signed [SW-1:0]           mag;
	logic signed [SW-1:0]           quo_signed;
	logic signed [SB-1:0]           avg_y;

	logic signed [SB-1:0]           y_q;
	logic [ssf_pkg::LEN_W-1:0]      rep_q;

	logic                           res_valid_q;
	logic signed [SB-1:0]           res_sample_q;
	logic [ssf_pkg::COUNT_W-1:0]    res_count_q;
	logic                           res_last_q;
	logic                           out_free;
	logic                           emit_last;

	assign len_eff = ssf_pkg::clamp_len(cfg_len_q);
	assign alpha   = ssf_pkg::clamp_gain(cfg_gain_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q <= ssf_pkg::MODE_EXP;
			cfg_len_q  <= ssf_pkg::LEN_CFG_W'(16);
			cfg_gain_q <= ssf_pkg::GAIN_W'(16384);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssf_pkg::CFG_MODE: cfg_mode_q <= cfg_data[0];
				ssf_pkg::CFG_LEN:  cfg_len_q  <= cfg_data[ssf_pkg::LEN_CFG_W-1:0];
				ssf_pkg::CFG_GAIN: cfg_gain_q <= cfg_data[ssf_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cur_active    = active_q && !record_start;
		cur_prev_samp = record_start ? '0 : prev_samp_q;
		cur_count     = record_start ? '0 : count_q;
		cur_fill      = record_start ? '0 : fill_q;
		cur_wp        = record_start ? '0 : wp_q;
		crossed = cur_active &&
			((sample > 0 && cur_prev_samp < 0) || (sample < 0 && cur_prev_samp > 0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			prev_samp_q <= '0;
			prev_out_q  <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			prev_fill_q <= '0;
			wp_q        <= '0;
		end else if (cmd.accept) begin
			active_q    <= 1'b1;
			prev_samp_q <= sample;
			if (record_start)
				prev_out_q <= '0;
			count_q     <= (crossed && cur_count != ssf_pkg::COUNT_MAX) ?
				cur_count + ssf_pkg::COUNT_W'(1) : cur_count;
			prev_fill_q <= cur_fill;
			fill_q      <= (cur_fill < ssf_pkg::FILL_W'(ssf_pkg::WINDOW_MAX)) ?
				cur_fill + ssf_pkg::FILL_W'(1) : cur_fill;
			wp_q        <= (cur_wp == ssf_pkg::PTR_W'(ssf_pkg::WINDOW_MAX - 1)) ?
				'0 : cur_wp + ssf_pkg::PTR_W'(1);
		end else if (cmd.exp_fin) begin
			prev_out_q <= exp_y;
		end else if (cmd.div_fin) begin
			prev_out_q <= avg_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= sample;
			first_q <= !cur_active;
		end
	end

	// exponential smoothing
	assign diff = {x_q[SB-1], x_q} - {prev_out_q[SB-1], prev_out_q};

	always_ff @(posedge clk) begin
		if (cmd.mul)
			product_s1 <= diff * $signed({1'b0, alpha});
	end

	always_comb begin
		rounded  = product_s1 + ssf_pkg::ROUND_HALF;
		step     = rounded >>> ssf_pkg::ALPHA_FRAC;
		exp_wide = {{(SW-SB){prev_out_q[SB-1]}}, prev_out_q} + step[SW-1:0];
		exp_y    = first_q ? x_q : ssf_pkg::sat_sample(exp_wide);
	end

	// window sum, newest sample first
	always_comb begin
		addr_raw = {1'b0, wp_q} + (ssf_pkg::PTR_W+1)'(ssf_pkg::WINDOW_MAX - 1) - {1'b0, k_q};
		if (addr_raw >= (ssf_pkg::PTR_W+1)'(ssf_pkg::WINDOW_MAX))
			addr_raw = addr_raw - (ssf_pkg::PTR_W+1)'(ssf_pkg::WINDOW_MAX);
		rd_addr = addr_raw[ssf_pkg::PTR_W-1:0];
	end

	ssf_ram #(
		.WIDTH(SB),
		.DEPTH(ssf_pkg::WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (cur_wp),
		.wdata (sample),
		.re    (cmd.rd_issue),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_s1 <= 1'b0;
		else
			rd_vld_s1 <= cmd.rd_issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			k_q   <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.rd_issue)
				k_q <= k_q + ssf_pkg::PTR_W'(1);
			if (rd_vld_s1)
				sum_q <= sum_q + {{(SW-SB){rdata[SB-1]}}, rdata};
		end
	end

	// restoring divide of |sum| by window length, one bit a cycle
	always_comb begin
		shifted    = {rem_q, quo_q[ssf_pkg::MAG_W-1]};
		trial      = shifted - {1'b0, len_eff};
		mag        = sum_q[SW-1] ? -sum_q : sum_q;
		quo_signed = {1'b0, quo_q};
		avg_y      = ssf_pkg::sat_sample(neg_q ? -quo_signed : quo_signed);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q     <= sum_q[SW-1];
			quo_q     <= mag[ssf_pkg::MAG_W-1:0];
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[ssf_pkg::LEN_W]) begin
				rem_q <= trial[ssf_pkg::LEN_W-1:0];
				quo_q <= {quo_q[ssf_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[ssf_pkg::LEN_W-1:0];
				quo_q <= {quo_q[ssf_pkg::MAG_W-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + ssf_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_fin) begin
			y_q   <= exp_y;
			rep_q <= '0;
		end else if (cmd.div_fin) begin
			y_q   <= avg_y;
			rep_q <= '0;
		end else if (cmd.emit) begin
			rep_q <= rep_q + ssf_pkg::LEN_W'(1);
		end
	end

	// output register
	assign out_free  = !res_valid_q || !result_stall;
	assign emit_last = (cfg_mode_q == ssf_pkg::MODE_EXP) || (prev_fill_q >= len_eff) ||
		(rep_q == len_eff - ssf_pkg::LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_sample_q <= y_q;
			res_count_q  <= count_q;
			res_last_q   <= emit_last;
		end
	end

	assign result_valid    = res_valid_q;
	assign filtered_sample = res_sample_q;
	assign crossing_count  = res_count_q;
	assign burst_last      = res_last_q;

	always_comb begin
		status.mode_avg    = (cfg_mode_q == ssf_pkg::MODE_AVG);
		status.fill_ge_len = (fill_q >= len_eff);
		status.rd_last     = (ssf_pkg::LEN_W'(k_q) == len_eff - ssf_pkg::LEN_W'(1));
		status.div_last    = (div_cnt_q == ssf_pkg::DIV_CNT_W'(ssf_pkg::MAG_W - 1));
		status.out_free    = out_free;
		status.emit_last   = emit_last;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("beat loaded into a full output register");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res_valid_q)
		else $error("loaded beat not presented");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < len_eff))
		else $error("divider remainder out of range");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ssf_pkg::FILL_W'(ssf_pkg::WINDOW_MAX))
		else $error("fill count beyond window store depth");

endmodule

// File: hdl/sample_smoothing_filter_top.sv
// Sample smoothing filter: exponential smoothing or moving average over audio samples,
// with a saturating count of sign changes per record.
// Input channel (item_valid/item_stall): one beat carries sample and record_start.
// Result channel (result_valid/result_stall): filtered_sample, crossing_count, burst_last;
// burst_last marks the final beat produced by an input beat.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 mode, 1 window length,
// 2 gain; cfg_ready is always high, write only while the block is idle.
// One input beat at a time. Exponential mode: load, multiply and smoothing states,
// then the result is loaded into the output register. Moving-average mode: the
// window is re-read from the sample RAM one entry per cycle, then a 22-step serial
// divider runs; then one beat per cycle for a burst unless result_stall holds it.
// Cost is set by the RAM read port and the divider loop.
// A new input beat is taken once the last result is in the output register or none is due.
// Stalling the result channel holds the output register and, while a beat waits, the sequencer.
// Reset (arst_n low) clears control and record state and restores the default config;
// the first sample after reset starts a record. No clearing pass is needed.
module sample_smoothing_filter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ssf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic signed [ssf_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   record_start,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [ssf_pkg::SAMPLE_BITS-1:0] filtered_sample,
	output logic [ssf_pkg::COUNT_W-1:0]            crossing_count,
	output logic                                   burst_last
);

	ssf_pkg::cmd_t    cmd;
	ssf_pkg::status_t status;

	assign cfg_ready = 1'b1;

	ssf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	ssf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample          (sample),
		.record_start    (record_start),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.filtered_sample (filtered_sample),
		.crossing_count  (crossing_count),
		.burst_last      (burst_last),
		.cmd             (cmd),
		.status          (status)
	);

endmodule

// File: test/ssf_checker.sv
module ssf_checker
	import ssf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          record_start,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic signed [SAMPLE_BITS-1:0] filtered_sample,
	input  logic [COUNT_W-1:0]            crossing_count,
	input  logic                          burst_last,
	output int                            pending,
	output int                            errors
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] level;
		logic [COUNT_W-1:0]            crossings;
		logic                          tail;
	} smoothed_t;

	smoothed_t pending_out[$];

	logic                          mode_avg;
	logic [LEN_CFG_W-1:0]          win_reg;
	logic [GAIN_W-1:0]             gain_reg;
	logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
	int                            fill;
	int                            wr_ptr;
	logic signed [SAMPLE_BITS-1:0] last_out;
	logic signed [SAMPLE_BITS-1:0] last_in;
	logic [COUNT_W-1:0]            sign_flips;
	logic                          rec_open;

	function automatic int polarity(input logic signed [SAMPLE_BITS-1:0] v);
		if (v > 0)
			return 1;
		if (v < 0)
			return -1;
		return 0;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint v);
		longint hi;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		if (v > hi)
			return SAMPLE_BITS'(hi);
		if (v < -hi - 1)
			return SAMPLE_BITS'(-hi - 1);
		return SAMPLE_BITS'(v);
	endfunction

	task automatic smooth_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic restart);
		int        len;
		int        prev_fill;
		int        reps;
		longint    alpha;
		longint    prod;
		longint    acc;
		logic signed [SAMPLE_BITS-1:0] y;
		smoothed_t beat;
		len = (win_reg == 0) ? 1 : ((int'(win_reg) > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
		alpha = (gain_reg > 16'd32768) ? 32768 : longint'(gain_reg);
		if (restart) begin
			fill = 0;
			wr_ptr = 0;
			last_out = '0;
			last_in = '0;
			sign_flips = '0;
			rec_open = 1'b0;
		end
		if (rec_open && polarity(x) * polarity(last_in) < 0 && sign_flips != COUNT_MAX)
			sign_flips = sign_flips + 1'b1;
		last_in = x;
		history[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
		prev_fill = fill;
		if (fill < WINDOW_MAX)
			fill = fill + 1;
		if (mode_avg == MODE_EXP) begin
			if (rec_open) begin
				// floor of (alpha*diff + half) / one
				prod = alpha * (longint'(x) - longint'(last_out)) + 16384;
				y = clip(longint'(last_out) + (prod >>> ALPHA_FRAC));
			end else begin
				y = x;
			end
			last_out = y;
			beat.level = y;
			beat.crossings = sign_flips;
			beat.tail = 1'b1;
			pending_out.push_back(beat);
		end else if (fill >= len) begin
			reps = (prev_fill < len) ? len : 1;
			acc = 0;
			for (int k = 0; k < len; k++)
				acc += longint'(history[(wr_ptr + WINDOW_MAX - 1 - k) % WINDOW_MAX]);
			y = clip(acc / len);
			last_out = y;
			for (int n = 0; n < reps; n++) begin
				beat.level = y;
				beat.crossings = sign_flips;
				beat.tail = (n == reps - 1);
				pending_out.push_back(beat);
			end
		end
		rec_open = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int        bad;
		smoothed_t want;
		if (!arst_n) begin
			mode_avg <= MODE_EXP;
			win_reg <= LEN_CFG_W'(16);
			gain_reg <= GAIN_W'(16384);
			fill = 0;
			wr_ptr = 0;
			last_out = '0;
			last_in = '0;
			sign_flips = '0;
			rec_open = 1'b0;
			pending_out.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode_avg = cfg_data[0];
					CFG_LEN:  win_reg = cfg_data[LEN_CFG_W-1:0];
					CFG_GAIN: gain_reg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				smooth_sample(sample, record_start);
			if (result_valid && !result_stall) begin
				if (pending_out.size() == 0) begin
					$display("%0t unexpected beat: expected none, got %0d/%0d/%0b", $time,
						filtered_sample, crossing_count, burst_last);
					bad++;
				end else begin
					want = pending_out.pop_front();
					if (filtered_sample !== want.level) begin
						$display("%0t filtered_sample: expected %0d, got %0d", $time,
							want.level, filtered_sample);
						bad++;
					end
					if (crossing_count !== want.crossings) begin
						$display("%0t crossing_count: expected %0d, got %0d", $time,
							want.crossings, crossing_count);
						bad++;
					end
					if (burst_last !== want.tail) begin
						$display("%0t burst_last: expected %0b, got %0b", $time,
							want.tail, burst_last);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			pending <= pending_out.size();
		end
	end

endmodule

// File: test/tb_sample_smoothing_filter_top.sv
module tb_sample_smoothing_filter_top;
	import ssf_pkg::*;

	localparam int RANDOM_ITEMS = 380;
	localparam int DRAIN_CYCLES = 2 * WINDOW_MAX + 40;
	localparam int STALL_LIMIT  = 3000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          item_valid;
	logic                          item_stall;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          record_start;
	logic                          result_valid;
	logic                          result_stall;
	logic signed [SAMPLE_BITS-1:0] filtered_sample;
	logic [COUNT_W-1:0]            crossing_count;
	logic                          burst_last;
	int                            pending;
	int                            errors;
	int                            idle_cycles;
	int                            random_sent;
	bit                            send_calm;
	bit                            drain_calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sample_smoothing_filter_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.sample         (sample),
		.record_start   (record_start),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.filtered_sample(filtered_sample),
		.crossing_count (crossing_count),
		.burst_last     (burst_last)
	);

	ssf_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.sample         (sample),
		.record_start   (record_start),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.filtered_sample(filtered_sample),
		.crossing_count (crossing_count),
		.burst_last     (burst_last),
		.pending        (pending),
		.errors         (errors)
	);

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic restart);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		sample <= s;
		record_start <= restart;
		do @(posedge clk); while (item_stall);
	endtask

	// block must be idle before any register write
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic mode, input logic [LEN_CFG_W-1:0] len,
		input logic [GAIN_W-1:0] gain);
		cfg_beat(CFG_MODE, CFG_DATA_W'(mode));
		cfg_beat(CFG_LEN, CFG_DATA_W'(len));
		cfg_beat(CFG_GAIN, CFG_DATA_W'(gain));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_BITS'(32767);
			1: return SAMPLE_BITS'(-32768);
			2: return '0;
			3, 4: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_CFG_W-1:0] pick_len();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return LEN_CFG_W'(1);
			2: return LEN_CFG_W'(WINDOW_MAX);
			3: return LEN_CFG_W'($urandom_range(WINDOW_MAX + 1, 126));
			4: return '1;
			default: return LEN_CFG_W'($urandom_range(2, 10));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_ONE;
			2: return '1;
			3: return GAIN_W'($urandom_range(32769, 65534));
			4: return GAIN_W'(1);
			default: return GAIN_W'($urandom_range(0, 32768));
		endcase
	endfunction

	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			int hold;
			if ($urandom_range(0, 29) == 0)
				drain_calm = !drain_calm;
			hold = drain_calm ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[sample_smoothing_filter_top] ERROR");
			$finish;
		end
	end

	initial begin
		int span;
		int start_odds;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		sample = '0;
		record_start = 1'b0;
		idle_cycles = 0;
		random_sent = 0;
		send_calm = 1'b0;
		drain_calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// defaults after reset: exponential, alpha one half
		send_sample(SAMPLE_BITS'(32767), 1'b0);
		send_sample(SAMPLE_BITS'(-32768), 1'b0);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_BITS'(1), 1'b0);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_BITS'(-1), 1'b0);
		send_sample(SAMPLE_BITS'(1), 1'b1);
		send_sample(SAMPLE_BITS'(2), 1'b0);
		send_sample(SAMPLE_BITS'(1), 1'b0);
		settle();
		program_regs(MODE_EXP, '0, '1);
		send_sample(SAMPLE_BITS'(-32768), 1'b1);
		send_sample(SAMPLE_BITS'(32767), 1'b0);
		settle();
		program_regs(MODE_EXP, '1, '0);
		cfg_beat(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_BITS'(12345), 1'b0);
		settle();
		program_regs(MODE_AVG, '0, GAIN_W'(16384));
		send_sample(SAMPLE_BITS'(-7), 1'b0);
		send_sample(SAMPLE_BITS'(7), 1'b0);
		settle();
		program_regs(MODE_AVG, LEN_CFG_W'(3), GAIN_W'(16384));
		send_sample(SAMPLE_BITS'(32767), 1'b1);
		send_sample(SAMPLE_BITS'(32767), 1'b0);
		send_sample(SAMPLE_BITS'(32767), 1'b0);
		send_sample(SAMPLE_BITS'(-32768), 1'b0);
		send_sample(SAMPLE_BITS'(-3), 1'b0);
		settle();
		program_regs(MODE_AVG, LEN_CFG_W'(5), GAIN_W'(16384));
		send_sample(SAMPLE_BITS'(1), 1'b0);
		settle();
		program_regs(MODE_AVG, LEN_CFG_W'(8), GAIN_W'(16384));
		send_sample(SAMPLE_BITS'(2), 1'b0);
		send_sample(SAMPLE_BITS'(3), 1'b0);
		settle();
		program_regs(MODE_EXP, LEN_CFG_W'(8), GAIN_W'(16384));
		send_sample(SAMPLE_BITS'(-100), 1'b0);

		// random phases; records often run across phases
		while (random_sent < RANDOM_ITEMS) begin
			settle();
			program_regs($urandom_range(0, 1) ? MODE_AVG : MODE_EXP, pick_len(), pick_gain());
			span = $urandom_range(8, 40);
			start_odds = ($urandom_range(0, 3) == 0) ? 100 : 12;
			repeat (span) begin
				send_sample(pick_sample(), $urandom_range(1, start_odds) == 1);
				random_sent++;
			end
		end

		settle();
		if (errors == 0)
			$display("[sample_smoothing_filter_top] OK");
		else
			$display("[sample_smoothing_filter_top] ERROR");
		$finish;
	end

endmodule
